[src/tea_pkg.sv]
// shared types, constants and round functions for the tea block cipher
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  // cipher constants
  localparam logic [31:0] Delta         = 32'h9E3779B9;
  localparam int          DefaultRounds = 32;
  localparam int          WordW         = 32;
  localparam int          CfgIdxW       = 2;

  // key register indexes
  localparam logic [CfgIdxW-1:0] KeyIdxZero  = 2'd0;
  localparam logic [CfgIdxW-1:0] KeyIdxOne   = 2'd1;
  localparam logic [CfgIdxW-1:0] KeyIdxTwo   = 2'd2;
  localparam logic [CfgIdxW-1:0] KeyIdxThree = 2'd3;

  // operation codes on the kind field
  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  // block travelling down the cell chain
  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
  } tea_blk_t;

  // the full 128-bit key
  typedef struct packed {
    logic [WordW-1:0] k0;
    logic [WordW-1:0] k1;
    logic [WordW-1:0] k2;
    logic [WordW-1:0] k3;
  } tea_key_t;

  // running sum after n delta steps, mod 2^32, evaluated at elaboration
  function automatic logic [WordW-1:0] tea_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(Delta) * 64'(n);
    return prod[WordW-1:0];
  endfunction

  // tea mixing function of one half
  function automatic logic [WordW-1:0] tea_mix(input logic [WordW-1:0] x,
                                               input logic [WordW-1:0] sum,
                                               input logic [WordW-1:0] kl,
                                               input logic [WordW-1:0] kr);
    return ((x << 4) + kl) ^ (x + sum) ^ ((x >> 5) + kr);
  endfunction

endpackage

`default_nettype wire

[src/tea_if.sv]
// handshake channel interfaces for blocks, results and key writes
`timescale 1ns / 1ps
`default_nettype none

interface tea_in_if;
  import tea_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [WordW-1:0] first_word;
  logic [WordW-1:0] second_word;

  modport source (output valid, kind, first_word, second_word, input ready);
  modport sink   (input valid, kind, first_word, second_word, output ready);
endinterface

interface tea_out_if;
  import tea_pkg::*;
  logic             valid;
  logic             ready;
  logic [WordW-1:0] result_first_word;
  logic [WordW-1:0] result_second_word;

  modport source (output valid, result_first_word, result_second_word, input ready);
  modport sink   (input valid, result_first_word, result_second_word, output ready);
endinterface

interface tea_cfg_if;
  import tea_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/tea_key_regs.sv]
// key register bank written through the configuration channel
`timescale 1ns / 1ps
`default_nettype none

module tea_key_regs
  import tea_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tea_cfg_if.sink     cfg_i,
  output tea_key_t    key_o
);

  tea_key_t key_q, key_d;

  // writes are always taken
  assign cfg_i.ready = 1'b1;

  // select the register addressed by a write transaction
  always_comb begin
    key_d = key_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        KeyIdxZero:  key_d.k0 = cfg_i.data;
        KeyIdxOne:   key_d.k1 = cfg_i.data;
        KeyIdxTwo:   key_d.k2 = cfg_i.data;
        KeyIdxThree: key_d.k3 = cfg_i.data;
        default:     key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

[src/tea_cell.sv]
// one half-round cell of the tea pipeline, updates one half of the block
`timescale 1ns / 1ps
`default_nettype none

module tea_cell
  import tea_pkg::*;
#(
  parameter logic             IsSecond = 1'b0,
  parameter logic [WordW-1:0] SumEnc   = '0,
  parameter logic [WordW-1:0] SumDec   = '0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tea_key_t  key_i,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire tea_blk_t  blk_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output tea_blk_t       blk_o
);

  logic             valid_q;
  tea_blk_t         blk_q, blk_d;
  logic             upd_y;
  logic [WordW-1:0] src, dst, kl, kr, sum, mix, res;

  // stage frees up when empty or when its content moves on
  assign ready_o = !valid_q || ready_i;

  // encrypt updates y then z, decrypt updates z then y
  always_comb begin
    upd_y = (blk_i.kind == IsSecond);
    src   = upd_y ? blk_i.z  : blk_i.y;
    dst   = upd_y ? blk_i.y  : blk_i.z;
    kl    = upd_y ? key_i.k0 : key_i.k2;
    kr    = upd_y ? key_i.k1 : key_i.k3;
    sum   = (blk_i.kind == KindDecrypt) ? SumDec : SumEnc;
    mix   = tea_mix(src, sum, kl, kr);
    res   = (blk_i.kind == KindDecrypt) ? (dst - mix) : (dst + mix);
    blk_d = blk_i;
    if (upd_y) begin
      blk_d.y = res;
    end else begin
      blk_d.z = res;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      blk_q <= blk_d;
    end
  end

  assign valid_o = valid_q;
  assign blk_o   = blk_q;

endmodule

`default_nettype wire

[src/tea_block_cipher.sv]
// tea block cipher top level: key bank and a chain of half-round cells
// throughput: one block per cycle while the output is not stalled, set by one half-round cell per pipeline stage
// stalls at the output back up stage by stage, empty stages fill while stalled
// reset clears all stage valid flags and sets the four key words to zero
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int ROUNDS = DefaultRounds
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tea_cfg_if.sink   cfg_i,
  tea_in_if.sink    in_i,
  tea_out_if.source out_o
);

  localparam int Stages = 2 * ROUNDS;

  tea_key_t key;
  logic     valid [Stages+1];
  logic     ready [Stages+1];
  tea_blk_t blk   [Stages+1];

  // key registers
  tea_key_regs u_key_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .key_o  (key)
  );

  // input side of the chain
  assign valid[0]    = in_i.valid;
  assign in_i.ready  = ready[0];
  assign blk[0].kind = in_i.kind;
  assign blk[0].y    = in_i.first_word;
  assign blk[0].z    = in_i.second_word;

  // chain of half-round cells, two per round
  for (genvar h = 0; h < Stages; h++) begin : g_cell
    localparam int Round = h / 2;
    tea_cell #(
      .IsSecond (1'(h % 2)),
      .SumEnc   (tea_sum(Round + 1)),
      .SumDec   (tea_sum(ROUNDS - Round))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (key),
      .valid_i (valid[h]),
      .ready_o (ready[h]),
      .blk_i   (blk[h]),
      .valid_o (valid[h+1]),
      .ready_i (ready[h+1]),
      .blk_o   (blk[h+1])
    );
  end

  // last stage register drives the result channel
  assign out_o.valid              = valid[Stages];
  assign ready[Stages]            = out_o.ready;
  assign out_o.result_first_word  = blk[Stages].y;
  assign out_o.result_second_word = blk[Stages].z;

endmodule

`default_nettype wire
